// ----- rtl/core/lbfs_pkg.sv -----
// Shared types, codes and controller interface for the linked block file store.
package lbfs_pkg;

	localparam int DATA_W      = 32;
	localparam int FID_W       = 7;
	localparam int FIRST_BLOCK = 2;

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_RD  = 2'd1;
	localparam logic [1:0] KIND_DEL = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_NOSPACE  = 3'd2;
	localparam logic [2:0] ST_TOOLARGE = 3'd3;
	localparam logic [2:0] ST_DIRFULL  = 3'd4;
	localparam logic [2:0] ST_INVALID  = 3'd5;

	typedef struct packed {
		logic [1:0]              kind;
		logic [FID_W-1:0]        file_id;
		logic signed [DATA_W-1:0] value;
		logic                    last;
	} req_t;

	typedef struct packed {
		logic [FID_W-1:0]        file_id_res;
		logic signed [DATA_W-1:0] value_res;
		logic [2:0]              status;
		logic [6:0]              free_blocks;
		logic                    last_res;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ADD_CHK,
		S_SCAN,
		S_WRITE,
		S_PUSH,
		S_RD_HEAD,
		S_RD_POS,
		S_RD_DATA,
		S_RD_LINK,
		S_RD_FIN,
		S_DEL_HEAD,
		S_DEL_LINK,
		S_DEL_FIN
	} state_t;

	typedef struct packed {
		logic       take_req;
		logic       buf_word;
		logic       clr_add;
		logic       scan_init;
		logic       scan_step;
		logic       wr_init;
		logic       wr_step;
		logic       wr_term;
		logic       dir_add;
		logic       walk_init;
		logic       rd_issue;
		logic       rd_link;
		logic       next_blk;
		logic       free_cur;
		logic       dir_del;
		logic       pend_load;
		logic       push_pend;
		logic       push_last;
		logic       push_code;
		logic [2:0] code;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       last;
		logic       dir_hit;
		logic       add_err;
		logic       add_big;
		logic       add_nospace;
		logic       dir_full;
		logic       alloc_done;
		logic       i_lt_n;
		logic       steps_end;
		logic       cur_bad;
		logic       cur_is_end;
		logic       p_blk;
		logic       p_slot;
		logic       nmax;
		logic       word_term;
		logic       pend_v;
		logic       out_free;
	} sts_t;

endpackage

// ----- rtl/core/lbfs_ram.sv -----
// Generic single write, single read RAM with registered read data.
module lbfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 640
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/lbfs_dp.sv -----
// Datapath: add buffer, bitmap, directory, disk RAM, chain walk and result register.
module lbfs_dp #(
	parameter int NUM_BLOCKS     = 128,
	parameter int BLOCK_WORDS    = 5,
	parameter int DIR_ENTRIES    = 10,
	parameter int MAX_FILE_WORDS = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lbfs_pkg::req_t req,
	input  lbfs_pkg::cmd_t cmd,
	output lbfs_pkg::sts_t sts,
	output logic          res_valid,
	input  logic          res_ready,
	output lbfs_pkg::res_t res
);

	localparam int SLOT = BLOCK_WORDS - 1;
	localparam int KMAX = (MAX_FILE_WORDS + SLOT - 1) / SLOT;
	localparam int IW   = $clog2(NUM_BLOCKS);
	localparam int AW   = $clog2(NUM_BLOCKS * BLOCK_WORDS);
	localparam int PW   = $clog2(BLOCK_WORDS + 1);
	localparam int CW   = $clog2(MAX_FILE_WORDS + 2);
	localparam int BIW  = (MAX_FILE_WORDS > 1) ? $clog2(MAX_FILE_WORDS) : 1;
	localparam int KW   = $clog2(KMAX + 1);
	localparam int KIW  = (KMAX > 1) ? $clog2(KMAX) : 1;
	localparam int DW   = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
	localparam int FW   = $clog2(NUM_BLOCKS - 1);
	localparam int SW   = $clog2(NUM_BLOCKS + 1);
	localparam int DATW = lbfs_pkg::DATA_W;
	localparam int FIDW = lbfs_pkg::FID_W;
	localparam int CMPW = 8;

	lbfs_pkg::req_t req_q;

	logic [DATW-1:0] buf_q [MAX_FILE_WORDS];
	logic [CW-1:0]   cnt_q;
	logic [KW-1:0]   kcnt_q;
	logic [PW-1:0]   kpos_q;
	logic            err_q;

	logic [IW-1:0]   b_q;
	logic [KW-1:0]   got_q;
	logic [IW-1:0]   blk_q [KMAX];
	logic [CW-1:0]   i_q;
	logic [KIW-1:0]  j_q;
	logic [PW-1:0]   p_q;

	logic [FIDW-1:0] name_q  [DIR_ENTRIES];
	logic [IW-1:0]   start_q [DIR_ENTRIES];
	logic [IW-1:0]   end_q   [DIR_ENTRIES];

	logic [NUM_BLOCKS-1:0] used_q;
	logic [FW-1:0]         free_q;

	logic [IW-1:0]   cur_q;
	logic            bad_q;
	logic [IW-1:0]   endb_q;
	logic [SW-1:0]   steps_q;
	logic [CW-1:0]   n_q;
	logic [DW-1:0]   slot_q;
	logic [DATW-1:0] pend_q;
	logic            pend_v_q;

	lbfs_pkg::res_t  res_q;
	logic            res_v_q;

	logic            hit;
	logic [DW-1:0]   hit_idx;
	logic            fslot_ok;
	logic [DW-1:0]   fslot;
	logic            out_free;

	logic            we;
	logic [AW-1:0]   waddr;
	logic [DATW-1:0] wdata;
	logic            re;
	logic [AW-1:0]   raddr;
	logic [DATW-1:0] rdata;

	function automatic logic [AW-1:0] mk_addr(input logic [IW-1:0] blk, input logic [PW-1:0] pos);
		mk_addr = AW'(blk) * AW'(BLOCK_WORDS) + AW'(pos);
	endfunction

	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		fslot_ok = 1'b0;
		fslot    = '0;
		for (int d = DIR_ENTRIES - 1; d >= 0; d--) begin
			if (name_q[d] == req_q.file_id && req_q.file_id != '0) begin
				hit     = 1'b1;
				hit_idx = DW'(d);
			end
			if (name_q[d] == '0) begin
				fslot_ok = 1'b1;
				fslot    = DW'(d);
			end
		end
	end

	assign out_free = !res_v_q || res_ready;

	always_comb begin
		sts             = '0;
		sts.kind        = req_q.kind;
		sts.last        = req_q.last;
		sts.dir_hit     = hit;
		sts.add_err     = err_q || (req_q.file_id == '0);
		sts.add_big     = cnt_q > CW'(MAX_FILE_WORDS);
		sts.add_nospace = CMPW'(free_q) < CMPW'(kcnt_q);
		sts.dir_full    = !fslot_ok;
		sts.alloc_done  = got_q == kcnt_q;
		sts.i_lt_n      = i_q < cnt_q;
		sts.steps_end   = steps_q == SW'(NUM_BLOCKS);
		sts.cur_bad     = bad_q;
		sts.cur_is_end  = cur_q == endb_q;
		sts.p_blk       = p_q == PW'(BLOCK_WORDS);
		sts.p_slot      = p_q == PW'(SLOT);
		sts.nmax        = n_q == CW'(MAX_FILE_WORDS);
		sts.word_term   = rdata == '1;
		sts.pend_v      = pend_v_q;
		sts.out_free    = out_free;
	end

	always_comb begin
		we    = 1'b0;
		waddr = mk_addr(blk_q[j_q], p_q);
		wdata = buf_q[i_q[BIW-1:0]];
		if (cmd.wr_step) begin
			we = 1'b1;
			if (p_q == PW'(SLOT)) begin
				waddr = mk_addr(blk_q[j_q], PW'(SLOT));
				wdata = DATW'(blk_q[KIW'(j_q + 1'b1)]);
			end
		end else if (cmd.wr_term) begin
			we    = 1'b1;
			wdata = '1;
		end
		re    = cmd.rd_issue || cmd.rd_link;
		raddr = cmd.rd_link ? mk_addr(cur_q, PW'(SLOT)) : mk_addr(cur_q, p_q);
	end

	lbfs_ram #(
		.WIDTH(DATW),
		.DEPTH(NUM_BLOCKS * BLOCK_WORDS)
	) u_disk (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.take_req) begin
			req_q <= req;
		end
		if (cmd.buf_word && cnt_q < CW'(MAX_FILE_WORDS)) begin
			buf_q[cnt_q[BIW-1:0]] <= req_q.value;
		end
		if (cmd.scan_step && !used_q[b_q]) begin
			blk_q[got_q[KIW-1:0]] <= b_q;
		end
		if (cmd.walk_init) begin
			endb_q <= end_q[hit_idx];
			slot_q <= hit_idx;
		end
		if (cmd.pend_load) begin
			pend_q <= rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			kcnt_q   <= '0;
			kpos_q   <= '0;
			err_q    <= 1'b0;
			b_q      <= '0;
			got_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			p_q      <= '0;
			used_q   <= NUM_BLOCKS'(3);
			free_q   <= FW'(NUM_BLOCKS - 2);
			cur_q    <= '0;
			bad_q    <= 1'b0;
			steps_q  <= '0;
			n_q      <= '0;
			pend_v_q <= 1'b0;
			res_v_q  <= 1'b0;
			for (int d = 0; d < DIR_ENTRIES; d++) begin
				name_q[d]  <= '0;
				start_q[d] <= '0;
				end_q[d]   <= '0;
			end
		end else begin
			if (cmd.buf_word) begin
				if (req_q.value == '1) begin
					err_q <= 1'b1;
				end
				if (cnt_q < CW'(MAX_FILE_WORDS)) begin
					if (kpos_q == '0) begin
						kcnt_q <= kcnt_q + 1'b1;
					end
					kpos_q <= (kpos_q == PW'(SLOT - 1)) ? '0 : kpos_q + 1'b1;
				end
				if (cnt_q <= CW'(MAX_FILE_WORDS)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.clr_add) begin
				cnt_q  <= '0;
				kcnt_q <= '0;
				kpos_q <= '0;
				err_q  <= 1'b0;
			end
			if (cmd.scan_init) begin
				b_q   <= IW'(lbfs_pkg::FIRST_BLOCK);
				got_q <= '0;
			end
			if (cmd.scan_step) begin
				b_q <= b_q + 1'b1;
				if (!used_q[b_q]) begin
					used_q[b_q] <= 1'b1;
					got_q       <= got_q + 1'b1;
					free_q      <= free_q - 1'b1;
				end
			end
			if (cmd.wr_init) begin
				i_q <= '0;
				j_q <= '0;
				p_q <= '0;
			end
			if (cmd.wr_step) begin
				if (p_q == PW'(SLOT)) begin
					j_q <= j_q + 1'b1;
					p_q <= '0;
				end else begin
					i_q <= i_q + 1'b1;
					p_q <= p_q + 1'b1;
				end
			end
			if (cmd.dir_add) begin
				name_q[fslot]  <= req_q.file_id;
				start_q[fslot] <= blk_q[0];
				end_q[fslot]   <= blk_q[j_q];
			end
			if (cmd.walk_init) begin
				cur_q    <= start_q[hit_idx];
				bad_q    <= 1'b0;
				steps_q  <= '0;
				n_q      <= '0;
				p_q      <= '0;
				pend_v_q <= 1'b0;
			end
			if (cmd.next_blk) begin
				cur_q   <= rdata[IW-1:0];
				bad_q   <= rdata >= DATW'(NUM_BLOCKS);
				steps_q <= steps_q + 1'b1;
				p_q     <= '0;
			end
			if (cmd.free_cur && cur_q >= IW'(lbfs_pkg::FIRST_BLOCK) && used_q[cur_q]) begin
				used_q[cur_q] <= 1'b0;
				free_q        <= free_q + 1'b1;
			end
			if (cmd.dir_del) begin
				name_q[slot_q]  <= '0;
				start_q[slot_q] <= '0;
				end_q[slot_q]   <= '0;
			end
			if (cmd.push_pend && cmd.push_last) begin
				pend_v_q <= 1'b0;
			end
			if (cmd.pend_load) begin
				pend_v_q <= 1'b1;
				n_q      <= n_q + 1'b1;
				p_q      <= p_q + 1'b1;
			end
			if (cmd.push_pend || cmd.push_code) begin
				res_v_q <= 1'b1;
			end else if (res_ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_pend) begin
			res_q.file_id_res <= req_q.file_id;
			res_q.value_res   <= pend_q;
			res_q.status      <= lbfs_pkg::ST_OK;
			res_q.free_blocks <= 7'(free_q);
			res_q.last_res    <= cmd.push_last;
		end else if (cmd.push_code) begin
			res_q.file_id_res <= req_q.file_id;
			res_q.value_res   <= '0;
			res_q.status      <= cmd.code;
			res_q.free_blocks <= 7'(free_q);
			res_q.last_res    <= 1'b1;
		end
	end

	assign res_valid = res_v_q;
	assign res       = res_q;

endmodule

// ----- rtl/core/lbfs_ctrl.sv -----
// Controller state machine sequencing add, read and delete requests.
module lbfs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  lbfs_pkg::sts_t sts,
	output lbfs_pkg::cmd_t cmd
);

	lbfs_pkg::state_t state_q, state_d;
	logic [2:0]       code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbfs_pkg::S_IDLE;
			code_q  <= lbfs_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		case (state_q)
			lbfs_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = lbfs_pkg::S_DECODE;
				end
			end
			lbfs_pkg::S_DECODE: begin
				case (sts.kind)
					lbfs_pkg::KIND_ADD: begin
						state_d = sts.last ? lbfs_pkg::S_ADD_CHK : lbfs_pkg::S_IDLE;
					end
					lbfs_pkg::KIND_RD: begin
						if (sts.dir_hit) begin
							state_d = lbfs_pkg::S_RD_HEAD;
						end else begin
							code_d  = lbfs_pkg::ST_NOTFOUND;
							state_d = lbfs_pkg::S_PUSH;
						end
					end
					lbfs_pkg::KIND_DEL: begin
						if (sts.dir_hit) begin
							state_d = lbfs_pkg::S_DEL_HEAD;
						end else begin
							code_d  = lbfs_pkg::ST_NOTFOUND;
							state_d = lbfs_pkg::S_PUSH;
						end
					end
					default: state_d = lbfs_pkg::S_IDLE;
				endcase
			end
			lbfs_pkg::S_ADD_CHK: begin
				state_d = lbfs_pkg::S_PUSH;
				if (sts.add_err) begin
					code_d = lbfs_pkg::ST_INVALID;
				end else if (sts.add_big) begin
					code_d = lbfs_pkg::ST_TOOLARGE;
				end else if (sts.add_nospace) begin
					code_d = lbfs_pkg::ST_NOSPACE;
				end else if (sts.dir_full) begin
					code_d = lbfs_pkg::ST_DIRFULL;
				end else begin
					state_d = lbfs_pkg::S_SCAN;
				end
			end
			lbfs_pkg::S_SCAN: begin
				if (sts.alloc_done) begin
					state_d = lbfs_pkg::S_WRITE;
				end
			end
			lbfs_pkg::S_WRITE: begin
				if (!sts.i_lt_n) begin
					code_d  = lbfs_pkg::ST_OK;
					state_d = lbfs_pkg::S_PUSH;
				end
			end
			lbfs_pkg::S_PUSH: begin
				if (sts.out_free) begin
					state_d = lbfs_pkg::S_IDLE;
				end
			end
			lbfs_pkg::S_RD_HEAD: begin
				state_d = (sts.steps_end || sts.cur_bad) ? lbfs_pkg::S_RD_FIN : lbfs_pkg::S_RD_POS;
			end
			lbfs_pkg::S_RD_POS: begin
				if (sts.nmax) begin
					state_d = lbfs_pkg::S_RD_FIN;
				end else if (sts.cur_is_end) begin
					state_d = sts.p_blk ? lbfs_pkg::S_RD_FIN : lbfs_pkg::S_RD_DATA;
				end else begin
					state_d = sts.p_slot ? lbfs_pkg::S_RD_LINK : lbfs_pkg::S_RD_DATA;
				end
			end
			lbfs_pkg::S_RD_DATA: begin
				if (sts.cur_is_end && sts.word_term) begin
					state_d = lbfs_pkg::S_RD_FIN;
				end else if (!sts.pend_v || sts.out_free) begin
					state_d = lbfs_pkg::S_RD_POS;
				end
			end
			lbfs_pkg::S_RD_LINK: begin
				state_d = lbfs_pkg::S_RD_HEAD;
			end
			lbfs_pkg::S_RD_FIN: begin
				if (sts.pend_v) begin
					if (sts.out_free) begin
						state_d = lbfs_pkg::S_IDLE;
					end
				end else begin
					code_d  = lbfs_pkg::ST_NOTFOUND;
					state_d = lbfs_pkg::S_PUSH;
				end
			end
			lbfs_pkg::S_DEL_HEAD: begin
				if (sts.steps_end || sts.cur_bad || sts.cur_is_end) begin
					state_d = lbfs_pkg::S_DEL_FIN;
				end else begin
					state_d = lbfs_pkg::S_DEL_LINK;
				end
			end
			lbfs_pkg::S_DEL_LINK: begin
				state_d = lbfs_pkg::S_DEL_HEAD;
			end
			lbfs_pkg::S_DEL_FIN: begin
				code_d  = lbfs_pkg::ST_OK;
				state_d = lbfs_pkg::S_PUSH;
			end
			default: state_d = lbfs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.code  = code_q;
		req_ready = 1'b0;
		case (state_q)
			lbfs_pkg::S_IDLE: begin
				req_ready    = 1'b1;
				cmd.take_req = req_valid;
			end
			lbfs_pkg::S_DECODE: begin
				case (sts.kind)
					lbfs_pkg::KIND_ADD: cmd.buf_word  = 1'b1;
					lbfs_pkg::KIND_RD:  cmd.walk_init = sts.dir_hit;
					lbfs_pkg::KIND_DEL: cmd.walk_init = sts.dir_hit;
					default: cmd.buf_word = 1'b0;
				endcase
			end
			lbfs_pkg::S_ADD_CHK: begin
				if (sts.add_err || sts.add_big || sts.add_nospace || sts.dir_full) begin
					cmd.clr_add = 1'b1;
				end else begin
					cmd.scan_init = 1'b1;
				end
			end
			lbfs_pkg::S_SCAN: begin
				if (sts.alloc_done) begin
					cmd.wr_init = 1'b1;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			lbfs_pkg::S_WRITE: begin
				if (sts.i_lt_n) begin
					cmd.wr_step = 1'b1;
				end else begin
					cmd.wr_term = 1'b1;
					cmd.dir_add = 1'b1;
					cmd.clr_add = 1'b1;
				end
			end
			lbfs_pkg::S_PUSH: begin
				cmd.push_code = sts.out_free;
			end
			lbfs_pkg::S_RD_POS: begin
				if (!sts.nmax) begin
					if (sts.cur_is_end) begin
						cmd.rd_issue = !sts.p_blk;
					end else if (sts.p_slot) begin
						cmd.rd_link = 1'b1;
					end else begin
						cmd.rd_issue = 1'b1;
					end
				end
			end
			lbfs_pkg::S_RD_DATA: begin
				if (!(sts.cur_is_end && sts.word_term) && (!sts.pend_v || sts.out_free)) begin
					cmd.push_pend = sts.pend_v;
					cmd.pend_load = 1'b1;
				end
			end
			lbfs_pkg::S_RD_LINK: begin
				cmd.next_blk = 1'b1;
			end
			lbfs_pkg::S_RD_FIN: begin
				if (sts.pend_v && sts.out_free) begin
					cmd.push_pend = 1'b1;
					cmd.push_last = 1'b1;
				end
			end
			lbfs_pkg::S_DEL_HEAD: begin
				if (!(sts.steps_end || sts.cur_bad)) begin
					cmd.free_cur = 1'b1;
					cmd.rd_link  = !sts.cur_is_end;
				end
			end
			lbfs_pkg::S_DEL_LINK: begin
				cmd.next_blk = 1'b1;
			end
			lbfs_pkg::S_DEL_FIN: begin
				cmd.dir_del = 1'b1;
			end
			default: cmd.take_req = 1'b0;
		endcase
	end

endmodule

// ----- rtl/core/linked_block_file_store.sv -----
// Top level of the linked block file store: controller plus datapath.
//
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  lbfs_pkg::req_t
// res      out        res_valid / res_ready  lbfs_pkg::res_t
//
// A final add word scans the bitmap from block 2 up, one block at a time, and writes the
// disk words, data and links, one at a time through the single write port. Reads go
// through the registered disk RAM read word by word and link by link; deletes walk the
// chain block by block.
// Reset clears directory, bitmap and add state at once; disk words are never cleared.
// A stalled result holds in the output register; the next request is taken meanwhile.
module linked_block_file_store #(
	parameter int NUM_BLOCKS     = 128,
	parameter int BLOCK_WORDS    = 5,
	parameter int DIR_ENTRIES    = 10,
	parameter int MAX_FILE_WORDS = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  lbfs_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output lbfs_pkg::res_t res
);

	lbfs_pkg::cmd_t cmd;
	lbfs_pkg::sts_t sts;

	lbfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lbfs_dp #(
		.NUM_BLOCKS    (NUM_BLOCKS),
		.BLOCK_WORDS   (BLOCK_WORDS),
		.DIR_ENTRIES   (DIR_ENTRIES),
		.MAX_FILE_WORDS(MAX_FILE_WORDS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the linked block file store: directed table, then random traffic.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBLK = 128;
	localparam int BW = 5;
	localparam int NDIR = 10;
	localparam int MAXW = 20;
	localparam int LIMIT = 2000000;

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_ready;
	lbfs_pkg::req_t req = '0;
	logic res_valid;
	logic res_ready = 0;
	lbfs_pkg::res_t res;

	linked_block_file_store dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always #5 clk = ~clk;

	// shadow of the store
	logic [31:0] disk [NBLK*BW];
	logic [6:0] dname [NDIR];
	logic [6:0] dstart [NDIR];
	logic [6:0] dend [NDIR];
	logic used [NBLK];
	logic [31:0] abuf [MAXW];
	int acnt;
	logic aerr;

	lbfs_pkg::res_t pending_res[$];
	int errors = 0;
	int cycles = 0;
	logic busy_tail = 0;

	function automatic int free_count();
		int n = 0;
		for (int b = lbfs_pkg::FIRST_BLOCK; b < NBLK; b++) if (!used[b]) n++;
		return n;
	endfunction

	function automatic void queue_res(logic [6:0] f, logic [31:0] v, logic [2:0] st,
		logic l);
		lbfs_pkg::res_t r;
		r.file_id_res = f;
		r.value_res = v;
		r.status = st;
		r.free_blocks = 7'(free_count());
		r.last_res = l;
		pending_res.push_back(r);
	endfunction

	function automatic int find_file(logic [6:0] f);
		if (f == 0) return -1;
		for (int i = 0; i < NDIR; i++) if (dname[i] == f) return i;
		return -1;
	endfunction

	function automatic logic [31:0] disk_at(longint b, int p);
		longint a = b * BW + p;
		return (a < NBLK * BW) ? disk[a] : 32'd0;
	endfunction

	function automatic logic [2:0] store_file(logic [6:0] f);
		int n = acnt;
		int k, slot, got;
		int blk [MAXW];
		slot = -1;
		if (aerr || f == 0) return lbfs_pkg::ST_INVALID;
		if (n > MAXW) return lbfs_pkg::ST_TOOLARGE;
		k = (n + BW - 2) / (BW - 1);
		if (k == 0) k = 1;
		if (free_count() < k) return lbfs_pkg::ST_NOSPACE;
		for (int i = 0; i < NDIR; i++) if (dname[i] == 0 && slot < 0) slot = i;
		if (slot < 0) return lbfs_pkg::ST_DIRFULL;
		got = 0;
		for (int b = lbfs_pkg::FIRST_BLOCK; b < NBLK && got < k; b++)
			if (!used[b]) begin
				used[b] = 1;
				blk[got++] = b;
			end
		for (int i = 0; i < n; i++) disk[blk[i/(BW-1)]*BW + i%(BW-1)] = abuf[i];
		for (int b = 0; b + 1 < k; b++) disk[blk[b]*BW + BW-1] = 32'(blk[b+1]);
		disk[blk[k-1]*BW + (n - (k-1)*(BW-1))] = '1;
		dname[slot] = f;
		dstart[slot] = 7'(blk[0]);
		dend[slot] = 7'(blk[k-1]);
		return lbfs_pkg::ST_OK;
	endfunction

	function automatic void read_file(logic [6:0] f);
		int slot = find_file(f);
		int n = 0;
		longint cur;
		int e;
		logic [31:0] w;
		lbfs_pkg::res_t r;
		logic stop;
		if (slot >= 0) begin
			cur = dstart[slot];
			e = dend[slot];
			stop = 0;
			for (int s = 0; s < NBLK && n < MAXW && !stop; s++) begin
				if (cur >= NBLK) stop = 1;
				else if (cur == e) begin
					for (int p = 0; p < BW && n < MAXW && !stop; p++) begin
						w = disk_at(cur, p);
						if (w == '1) stop = 1;
						else begin
							queue_res(f, w, lbfs_pkg::ST_OK, 0);
							n++;
						end
					end
					stop = 1;
				end else begin
					for (int p = 0; p < BW-1 && n < MAXW; p++) begin
						queue_res(f, disk_at(cur, p), lbfs_pkg::ST_OK, 0);
						n++;
					end
					cur = longint'(disk_at(cur, BW-1));
				end
			end
		end
		if (n == 0) queue_res(f, 0, lbfs_pkg::ST_NOTFOUND, 1);
		else begin
			r = pending_res.pop_back();
			r.last_res = 1;
			pending_res.push_back(r);
		end
	endfunction

	function automatic logic [2:0] delete_file(logic [6:0] f);
		int slot = find_file(f);
		longint cur;
		int e;
		logic stop = 0;
		if (slot < 0) return lbfs_pkg::ST_NOTFOUND;
		cur = dstart[slot];
		e = dend[slot];
		for (int s = 0; s < NBLK && !stop; s++) begin
			if (cur >= NBLK) stop = 1;
			else begin
				if (cur >= lbfs_pkg::FIRST_BLOCK) used[cur] = 0;
				if (cur == e) stop = 1;
				else cur = longint'(disk_at(cur, BW-1));
			end
		end
		dname[slot] = 0;
		dstart[slot] = 0;
		dend[slot] = 0;
		return lbfs_pkg::ST_OK;
	endfunction

	function automatic void predict(lbfs_pkg::req_t q);
		logic [2:0] st;
		case (q.kind)
			lbfs_pkg::KIND_ADD: begin
				if (q.value == -1) aerr = 1;
				if (acnt < MAXW) abuf[acnt] = q.value;
				if (acnt <= MAXW) acnt++;
				if (q.last) begin
					st = store_file(q.file_id);
					acnt = 0;
					aerr = 0;
					queue_res(q.file_id, 0, st, 1);
				end
			end
			lbfs_pkg::KIND_RD: read_file(q.file_id);
			lbfs_pkg::KIND_DEL: begin
				st = delete_file(q.file_id);
				queue_res(q.file_id, 0, st, 1);
			end
			default: ;
		endcase
	endfunction

	function automatic int gap();
		int r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// valid stays up after an accept only when the next request follows at once
	task automatic send(lbfs_pkg::req_t q);
		int g;
		g = gap();
		if (g > 0) begin
			req_valid <= 0;
			repeat (g) @(posedge clk);
		end
		req <= q;
		req_valid <= 1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		predict(q);
	endtask

	task automatic send_add(logic [6:0] f, int n, logic bad);
		lbfs_pkg::req_t q;
		for (int i = 0; i < n; i++) begin
			q.kind = lbfs_pkg::KIND_ADD;
			q.file_id = f;
			q.value = $urandom;
			if (q.value == -1) q.value = 0;
			if (bad && i == n/2) q.value = -1;
			q.last = (i == n - 1);
			send(q);
		end
	endtask

	task automatic drain();
		req_valid <= 0;
		@(posedge clk);
		while (pending_res.size() != 0) @(posedge clk);
	endtask

	// result side: random back-pressure, check on handshake
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (pending_res.size() == 0) begin
					$display("%0t unexpected result act=%p", $realtime, res);
					errors++;
				end else if (pending_res[0] !== res) begin
					$display("%0t mismatch exp=%p act=%p", $realtime, pending_res[0], res);
					errors++;
					void'(pending_res.pop_front());
				end else void'(pending_res.pop_front());
			end
			res_ready <= ($urandom_range(0, 9) < 7) || busy_tail;
		end
	end

	always @(posedge clk) if (cycles >= LIMIT) begin
		$display("Regression FAIL");
		$finish;
	end

	typedef struct {
		lbfs_pkg::req_t q;
		logic chk;
		lbfs_pkg::res_t r;
	} row_t;

	row_t rows [$];

	function automatic row_t mk(logic [1:0] k, logic [6:0] f, logic [31:0] v, logic l,
		logic c, logic [2:0] st, logic [6:0] fb);
		row_t w;
		w.q = '{kind: k, file_id: f, value: v, last: l};
		w.chk = c;
		w.r = '{file_id_res: f, value_res: 0, status: st, free_blocks: fb, last_res: 1};
		return w;
	endfunction

	initial begin
		lbfs_pkg::res_t e;
		int nf;
		logic paused;
		for (int i = 0; i < NBLK*BW; i++) disk[i] = 0;
		for (int i = 0; i < NDIR; i++) begin
			dname[i] = 0; dstart[i] = 0; dend[i] = 0;
		end
		for (int b = 0; b < NBLK; b++) used[b] = (b < lbfs_pkg::FIRST_BLOCK);
		acnt = 0;
		aerr = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		rows.push_back(mk(lbfs_pkg::KIND_RD, 7'd1, 0, 0, 1, lbfs_pkg::ST_NOTFOUND, 7'd126));
		rows.push_back(mk(lbfs_pkg::KIND_DEL, 7'd127, 0, 0, 1, lbfs_pkg::ST_NOTFOUND, 7'd126));
		rows.push_back(mk(lbfs_pkg::KIND_ADD, 7'd0, 32'h5, 1, 1, lbfs_pkg::ST_INVALID, 7'd126));
		rows.push_back(mk(lbfs_pkg::KIND_ADD, 7'd3, 32'hFFFFFFFF, 1, 1,
			lbfs_pkg::ST_INVALID, 7'd126));
		rows.push_back(mk(2'd3, 7'd9, 32'h1, 1, 0, lbfs_pkg::ST_OK, 0));
		rows.push_back(mk(lbfs_pkg::KIND_ADD, 7'd127, 32'h7FFFFFFF, 0, 0, lbfs_pkg::ST_OK, 0));
		rows.push_back(mk(lbfs_pkg::KIND_ADD, 7'd127, 32'h80000000, 0, 0, lbfs_pkg::ST_OK, 0));
		rows.push_back(mk(lbfs_pkg::KIND_ADD, 7'd127, 32'h0, 0, 0, lbfs_pkg::ST_OK, 0));
		rows.push_back(mk(lbfs_pkg::KIND_RD, 7'd2, 0, 0, 1, lbfs_pkg::ST_NOTFOUND, 7'd126));
		rows.push_back(mk(lbfs_pkg::KIND_ADD, 7'd127, 32'hFFFFFFFE, 1, 1,
			lbfs_pkg::ST_OK, 7'd125));
		rows.push_back(mk(lbfs_pkg::KIND_RD, 7'd127, 0, 0, 0, lbfs_pkg::ST_OK, 0));
		rows.push_back(mk(lbfs_pkg::KIND_ADD, 7'd1, 32'h12345678, 1, 1,
			lbfs_pkg::ST_OK, 7'd124));
		rows.push_back(mk(lbfs_pkg::KIND_RD, 7'd1, 0, 1, 0, lbfs_pkg::ST_OK, 0));
		rows.push_back(mk(lbfs_pkg::KIND_DEL, 7'd127, 0, 0, 1, lbfs_pkg::ST_OK, 7'd125));
		rows.push_back(mk(lbfs_pkg::KIND_RD, 7'd127, 0, 0, 1, lbfs_pkg::ST_NOTFOUND, 7'd125));
		foreach (rows[i]) begin
			send(rows[i].q);
			if (rows[i].chk) begin
				e = pending_res[pending_res.size()-1];
				if (e !== rows[i].r) begin
					$display("%0t table row %0d exp=%p act=%p", $realtime, i, rows[i].r, e);
					errors++;
				end
			end
		end
		// exact fill, too large, full-size file, bad word, then fill the directory
		send_add(7'd10, 8, 0);
		send_add(7'd11, 21, 0);
		send_add(7'd12, 20, 0);
		send_add(7'd13, 1, 1);
		send('{kind: lbfs_pkg::KIND_RD, file_id: 7'd10, value: 0, last: 0});
		send('{kind: lbfs_pkg::KIND_RD, file_id: 7'd12, value: 0, last: 0});
		for (int i = 0; i < 8; i++) send_add(7'(20 + i), 1, 0);
		drain();
		for (int i = 0; i < NDIR; i++)
			if (dname[i] != 0)
				send('{kind: lbfs_pkg::KIND_DEL, file_id: dname[i], value: 0, last: 0});

		nf = 0;
		paused = 0;
		while (nf < 210) begin
			int r = $urandom_range(0, 99);
			lbfs_pkg::req_t q;
			int n;
			if (!paused && nf >= 100) begin
				drain();
				paused = 1;
			end
			if (r < 45) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 22) :
					$urandom_range(1, 9);
				send_add(7'($urandom_range(1, 15)), n, $urandom_range(0, 19) == 0);
				nf += n;
			end else begin
				q.kind = (r < 75) ? lbfs_pkg::KIND_RD : (r < 97) ? lbfs_pkg::KIND_DEL : 2'd3;
				q.file_id = (r % 7 == 0) ? 7'($urandom_range(0, 127)) :
					7'($urandom_range(1, 15));
				q.value = $urandom;
				q.last = 1'($urandom);
				if ($urandom_range(0, 9) == 0) begin
					// noise inside a pending add
					send('{kind: lbfs_pkg::KIND_ADD, file_id: 7'd5,
						value: $urandom & 32'h7FFF_FFFF, last: 0});
					nf++;
				end
				send(q);
				nf++;
			end
		end

		busy_tail = 1;
		drain();
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_res.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/core/lbfs_pkg.sv
rtl/core/lbfs_ram.sv
rtl/core/lbfs_dp.sv
rtl/core/lbfs_ctrl.sv
rtl/core/linked_block_file_store.sv
sim/tb.sv
